// ===== src/cpc_pkg.sv =====
// cpc_pkg: types, constants and the micro-rotation angle table of the
// rectangular/polar converter. No dependencies.
`timescale 1ns / 1ps

package cpc_pkg;

    // Datapath widths: Q16.16 coordinates carry 24 guard bits in a
    // 60-bit signed word; angles use 48 bits per full turn.
    localparam int GUARD      = 24;
    localparam int XY_W       = 60;
    localparam int Z_W        = 48;
    localparam int COORD_W    = 32;
    localparam int MAX_STAGES = 40;

    // Action codes
    localparam logic ACT_P2R = 1'b0;
    localparam logic ACT_R2P = 1'b1;

    // Limit gain 1/K as a 32-bit fraction
    localparam logic [31:0] GAIN_K = 32'h9B74EDA8;

    // 2^64 / (2*pi)
    localparam logic [63:0] INV_TWO_PI = 64'h28BE60DB9391054A;

    // Rounding offsets
    localparam logic [XY_W-1:0] RND_POS = XY_W'(64'd1 << (GUARD - 1));
    localparam logic [XY_W-1:0] RND_NEG = XY_W'((64'd1 << (GUARD - 1)) + 64'd1);
    localparam logic [Z_W-1:0]  ANG_RND = Z_W'(64'd1 << 15);
    localparam logic [Z_W-1:0]  HALF_TURN = Z_W'(64'd1 << (Z_W - 1));

    typedef logic [Z_W-1:0] t_angle_tab [MAX_STAGES];

    // One vector in flight through the rotation stages
    typedef struct packed {
        logic                   act;
        logic                   zero;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [Z_W-1:0]         z;
    } t_cordic;

    // One result beat
    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic [COORD_W-1:0]        out_radius;
        logic [COORD_W-1:0]        out_angle;
    } t_result;

    // Shift-subtract quotient, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Upper half of a 64 by 64 product, elaboration only
    function automatic logic [63:0] mul_hi64(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[127:64];
    endfunction

    // atan(2^-i) / (2*pi) in units of 2^-48 turn; series for atan scaled by 2^60
    function automatic t_angle_tab build_angle_tab();
        t_angle_tab  tab;
        logic [63:0] acc;
        logic [63:0] term;
        logic [63:0] d;
        logic [63:0] n;
        for (int i = 0; i < MAX_STAGES; i++) begin
            if (i == 0) begin
                tab[i] = Z_W'(64'd1 << 45);
            end else begin
                acc = '0;
                for (int k = 0; k < 31; k++) begin
                    d = 64'(2 * k + 1);
                    n = 64'(i) * d;
                    if (n <= 64'd60) begin
                        term = udiv64(64'd1 << (64'd60 - n), d);
                        acc  = (k % 2 == 1) ? acc - term : acc + term;
                    end
                end
                tab[i] = Z_W'((mul_hi64(acc, INV_TWO_PI) + 64'd2048) >> 12);
            end
        end
        return tab;
    endfunction

    localparam t_angle_tab ANGLE_TAB = build_angle_tab();

endpackage

// ===== src/cpc_if.sv =====
// cpc_if: valid/ready channel interfaces for input and result beats.
// No dependencies.
`timescale 1ns / 1ps

interface cpc_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] radius_in;
    logic [31:0]        angle_in;

    modport source (output valid, action, coord_x, coord_y, radius_in, angle_in,
                    input ready);
    modport sink   (input valid, action, coord_x, coord_y, radius_in, angle_in,
                    output ready);
endinterface

interface cpc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [31:0]        out_radius;
    logic [31:0]        out_angle;

    modport source (output valid, out_x, out_y, out_radius, out_angle, input ready);
    modport sink   (input valid, out_x, out_y, out_radius, out_angle, output ready);
endinterface

// ===== src/cpc_pre.sv =====
// cpc_pre: input conditioning stage; folds the vector into the right half
// plane (or the angle into +/- a quarter turn). Depends on cpc_pkg.
`timescale 1ns / 1ps

module cpc_pre (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic             i_action,
    input  logic [31:0]      i_coord_x,
    input  logic [31:0]      i_coord_y,
    input  logic [31:0]      i_radius_in,
    input  logic [31:0]      i_angle_in,
    output logic             o_valid,
    output cpc_pkg::t_cordic o_data
);
    import cpc_pkg::*;

    localparam int EXT_W = XY_W - COORD_W - GUARD;

    logic            r_valid;
    t_cordic         r_data;
    t_cordic         n_data;
    logic [XY_W-1:0] ext_r;
    logic [XY_W-1:0] ext_x;
    logic [XY_W-1:0] ext_y;
    logic [Z_W-1:0]  ang;

    // Scale to the guard-bit format and fold the start point
    always_comb begin
        ext_r = {{EXT_W{i_radius_in[31]}}, i_radius_in, {GUARD{1'b0}}};
        ext_x = {{EXT_W{i_coord_x[31]}}, i_coord_x, {GUARD{1'b0}}};
        ext_y = {{EXT_W{i_coord_y[31]}}, i_coord_y, {GUARD{1'b0}}};
        ang   = {i_angle_in, {(Z_W - COORD_W){1'b0}}};
        n_data.act  = i_action;
        n_data.zero = (i_coord_x == '0) && (i_coord_y == '0);
        if (i_action == ACT_P2R) begin
            // second and third quadrant: negate radius, move angle by half a turn
            n_data.y = '0;
            if (i_angle_in[31] ^ i_angle_in[30]) begin
                n_data.x = -ext_r;
                n_data.z = ang ^ HALF_TURN;
            end else begin
                n_data.x = ext_r;
                n_data.z = ang;
            end
        end else begin
            if (i_coord_x[31]) begin
                n_data.x = -ext_x;
                n_data.y = -ext_y;
                n_data.z = HALF_TURN;
            end else begin
                n_data.x = ext_x;
                n_data.y = ext_y;
                n_data.z = '0;
            end
        end
    end

    // Advance valid with the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== src/cpc_stage.sv =====
// cpc_stage: one registered CORDIC micro-rotation, shared by rotation and
// vectoring modes. Depends on cpc_pkg.
`timescale 1ns / 1ps

module cpc_stage #(
    parameter int SHIFT = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  cpc_pkg::t_cordic i_data,
    output logic             o_valid,
    output cpc_pkg::t_cordic o_data
);
    import cpc_pkg::*;

    logic                   r_valid;
    t_cordic                r_data;
    t_cordic                n_data;
    logic                   ccw;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    // Rotate toward zero residual angle, or toward the positive x axis
    always_comb begin
        ccw    = (i_data.act == ACT_P2R) ? !i_data.z[Z_W-1] : i_data.y[XY_W-1];
        dx     = $signed(i_data.y) >>> SHIFT;
        dy     = $signed(i_data.x) >>> SHIFT;
        n_data = i_data;
        if (ccw) begin
            n_data.x = i_data.x - dx;
            n_data.y = i_data.y + dy;
            n_data.z = i_data.z - ANGLE_TAB[SHIFT];
        end else begin
            n_data.x = i_data.x + dx;
            n_data.y = i_data.y - dy;
            n_data.z = i_data.z + ANGLE_TAB[SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== src/cpc_post.sv =====
// cpc_post: gain removal (split 32-bit multiplies), rounding, saturation
// and mode selection over four register stages. Depends on cpc_pkg.
`timescale 1ns / 1ps

module cpc_post (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  cpc_pkg::t_cordic i_data,
    output logic             o_valid,
    output cpc_pkg::t_result o_data
);
    import cpc_pkg::*;

    localparam int W_W = XY_W - GUARD;

    logic [3:0]       r_valid;

    // stage 1: sign and magnitude
    logic             r1_act;
    logic             r1_zero;
    logic             r1_neg_x;
    logic             r1_neg_y;
    logic [XY_W-1:0]  r1_mag_x;
    logic [XY_W-1:0]  r1_mag_y;
    logic [Z_W-1:0]   r1_z;

    // stage 2: partial products
    logic             r2_act;
    logic             r2_zero;
    logic             r2_neg_x;
    logic             r2_neg_y;
    logic [XY_W-1:0]  r2_hi_x;
    logic [XY_W-1:0]  r2_hi_y;
    logic [63:0]      r2_lo_x;
    logic [63:0]      r2_lo_y;
    logic [Z_W-1:0]   r2_z;

    // stage 3: gain-corrected magnitude
    logic             r3_act;
    logic             r3_zero;
    logic             r3_neg_x;
    logic             r3_neg_y;
    logic [XY_W-1:0]  r3_p_x;
    logic [XY_W-1:0]  r3_p_y;
    logic [Z_W-1:0]   r3_z;

    // stage 4: result
    t_result          r4_res;
    t_result          n4_res;

    logic [XY_W-1:0]  sum_x;
    logic [XY_W-1:0]  sum_y;
    logic [W_W-1:0]   w_x;
    logic [W_W-1:0]   w_y;
    logic [31:0]      sat_x;
    logic [31:0]      sat_y;
    logic [31:0]      radius;
    logic [Z_W-1:0]   z_rnd;

    // Clamp a rounded value to signed 32 bits
    function automatic logic [31:0] sat_s32(input logic [W_W-1:0] w);
        logic fits;
        fits = (w[W_W-1:31] == '0) || (w[W_W-1:31] == '1);
        if (fits) begin
            return w[31:0];
        end
        return w[W_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    // Stage 1: take magnitudes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_act   <= i_data.act;
            r1_zero  <= i_data.zero;
            r1_neg_x <= i_data.x[XY_W-1];
            r1_neg_y <= i_data.y[XY_W-1];
            r1_mag_x <= i_data.x[XY_W-1] ? -i_data.x : i_data.x;
            r1_mag_y <= i_data.y[XY_W-1] ? -i_data.y : i_data.y;
            r1_z     <= i_data.z;
        end
    end

    // Stage 2: multiply upper and lower halves by the gain
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_act   <= r1_act;
            r2_zero  <= r1_zero;
            r2_neg_x <= r1_neg_x;
            r2_neg_y <= r1_neg_y;
            r2_hi_x  <= XY_W'(r1_mag_x[XY_W-1:32]) * XY_W'(GAIN_K);
            r2_hi_y  <= XY_W'(r1_mag_y[XY_W-1:32]) * XY_W'(GAIN_K);
            r2_lo_x  <= 64'(r1_mag_x[31:0]) * 64'(GAIN_K);
            r2_lo_y  <= 64'(r1_mag_y[31:0]) * 64'(GAIN_K);
            r2_z     <= r1_z;
        end
    end

    // Stage 3: combine partial products (floor of m * K / 2^32)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_act   <= r2_act;
            r3_zero  <= r2_zero;
            r3_neg_x <= r2_neg_x;
            r3_neg_y <= r2_neg_y;
            r3_p_x   <= r2_hi_x + XY_W'(r2_lo_x[63:32]);
            r3_p_y   <= r2_hi_y + XY_W'(r2_lo_y[63:32]);
            r3_z     <= r2_z;
        end
    end

    // Stage 4: restore sign with the rounding offset folded in, clamp, then select the mode's fields
    always_comb begin
        sum_x  = r3_neg_x ? (~r3_p_x + RND_NEG) : (r3_p_x + RND_POS);
        sum_y  = r3_neg_y ? (~r3_p_y + RND_NEG) : (r3_p_y + RND_POS);
        w_x    = sum_x[XY_W-1:GUARD];
        w_y    = sum_y[XY_W-1:GUARD];
        sat_x  = sat_s32(w_x);
        sat_y  = sat_s32(w_y);
        z_rnd  = r3_z + ANG_RND;
        if (r3_neg_x && (r3_p_x != '0)) begin
            radius = '0;
        end else if (w_x[W_W-1:32] != '0) begin
            radius = '1;
        end else begin
            radius = w_x[31:0];
        end
        n4_res = '0;
        if (r3_act == ACT_P2R) begin
            n4_res.out_x = sat_x;
            n4_res.out_y = sat_y;
        end else if (!r3_zero) begin
            n4_res.out_radius = radius;
            n4_res.out_angle  = z_rnd[Z_W-1:Z_W-COORD_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_res <= n4_res;
        end
    end

    assign o_valid = r_valid[3];
    assign o_data  = r4_res;

endmodule

// ===== src/cartesian_polar_converter.sv =====
// cartesian_polar_converter: a conversion runs from input beat to result beat
// through one conditioning stage, one register stage per micro-rotation and
// four for gain removal and rounding. One beat is taken every cycle while
// in_ready is high; a two-beat output buffer lets the pipeline keep running
// while a result waits, and in_ready falls only when that buffer is full,
// which then holds the whole pipeline until a beat leaves. Depends on cpc_pkg,
// cpc_if, cpc_pre, cpc_stage and cpc_post.
`timescale 1ns / 1ps

module cartesian_polar_converter #(
    parameter int CORDIC_STAGES = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cpc_in_if.sink    i_in,
    cpc_out_if.source o_out
);
    import cpc_pkg::*;

    localparam logic [1:0] BUF_DEPTH = 2'd2;

    logic                   en;
    logic [CORDIC_STAGES:0] w_valid;
    t_cordic                w_data [CORDIC_STAGES+1];
    logic                   post_valid;
    t_result                post_data;

    logic [1:0]             r_cnt;
    t_result                r_head;
    t_result                r_tail;
    logic                   push;
    logic                   pop;

    // Pipeline runs while the output buffer has room
    assign en         = (r_cnt != BUF_DEPTH);
    assign i_in.ready = en;

    cpc_pre u_pre (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_in.valid),
        .i_action    (i_in.action),
        .i_coord_x   (i_in.coord_x),
        .i_coord_y   (i_in.coord_y),
        .i_radius_in (i_in.radius_in),
        .i_angle_in  (i_in.angle_in),
        .o_valid     (w_valid[0]),
        .o_data      (w_data[0])
    );

    // One micro-rotation per stage
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
        cpc_stage #(
            .SHIFT (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    cpc_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_valid[CORDIC_STAGES]),
        .i_data  (w_data[CORDIC_STAGES]),
        .o_valid (post_valid),
        .o_data  (post_data)
    );

    // Output buffer: head is shown, tail holds a second beat
    assign push = en && post_valid;
    assign pop  = (r_cnt != 2'd0) && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop))) begin
            r_head <= post_data;
        end else if (pop) begin
            r_head <= r_tail;
        end
        if (push && r_cnt == 2'd1 && !pop) begin
            r_tail <= post_data;
        end
    end

    assign o_out.valid      = (r_cnt != 2'd0);
    assign o_out.out_x      = r_head.out_x;
    assign o_out.out_y      = r_head.out_y;
    assign o_out.out_radius = r_head.out_radius;
    assign o_out.out_angle  = r_head.out_angle;

    // Back-pressure only when the buffer is full
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_cnt == BUF_DEPTH)
        else $error("input ready low with room in output buffer");

    // An accepted beat enters the conditioning stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> w_valid[0])
        else $error("accepted beat missing from first stage");

    // Full buffer with no drain freezes the pipeline
    a_hold_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == BUF_DEPTH) && !o_out.ready |=> $stable(w_valid) && !push)
        else $error("pipeline moved while output buffer full");

    // Modes never mix in one result
    a_mode_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.out_x != '0 || o_out.out_y != '0)
            |-> o_out.out_radius == '0 && o_out.out_angle == '0)
        else $error("rectangular and polar fields both set");

    // Buffer count stays within depth
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= BUF_DEPTH)
        else $error("output buffer count overflow");

endmodule

// ===== dv/cartesian_polar_converter_test.sv =====
// cartesian_polar_converter_test: self-checking bench for the CORDIC converter.
// Drives random and corner vectors in both modes and compares each result beat
// with a bit-exact predictor. Depends on cpc_pkg, cpc_if and the converter RTL.
`timescale 1ns / 1ps

module cartesian_polar_converter_test;

    import cpc_pkg::*;

    localparam int STAGES       = 32;
    localparam int LATENCY      = STAGES + 5;
    localparam int CLK_HALF     = 5;
    localparam int LIMIT_CYCLES = 800000;
    localparam int RANDOM_ITEMS = 1850;
    localparam int MAX_REPORTS  = 10;

    // Fixed-point constants of the conversion
    localparam int          FRAC_GUARD = 24;
    localparam logic [31:0] GAIN_INV   = 32'h9B74EDA8;
    localparam logic [63:0] TURN_RECIP = 64'h28BE60DB9391054A;
    localparam logic [63:0] LOW32      = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] LOW48      = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] HALF_REV   = 64'h0000_8000_0000_0000;

    typedef struct {
        logic        act;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] rad;
        logic [31:0] ang;
    } t_vec_req;

    logic i_clk;
    logic i_rst_n;

    cpc_in_if  vec_in ();
    cpc_out_if vec_out ();

    cartesian_polar_converter #(
        .CORDIC_STAGES(STAGES)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (vec_in),
        .o_out  (vec_out)
    );

    logic [63:0] rot_angle [STAGES];
    t_vec_req    vectors_to_send [$];
    t_result     results_due [$];
    int          n_items;
    int          n_sent     = 0;
    int          n_fail     = 0;
    int          n_reported = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Upper 64 bits of an unsigned 64x64 product
    function automatic logic [63:0] mul_upper(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[127:64];
    endfunction

    function automatic logic [63:0] shr_arith(input logic [63:0] v, input int s);
        int sh;
        sh = (s > 63) ? 63 : s;
        return v[63] ? ~((~v) >> sh) : (v >> sh);
    endfunction

    function automatic logic [63:0] sign_ext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    // Scale by 1/K on the magnitude, keep the sign
    function automatic logic [63:0] drop_gain(input logic [63:0] v);
        logic [63:0] m;
        logic [63:0] p;
        m = v[63] ? (64'd0 - v) : v;
        p = mul_upper(m, {GAIN_INV, 32'd0});
        return v[63] ? (64'd0 - p) : p;
    endfunction

    function automatic logic [31:0] round_clip_s32(input logic [63:0] v);
        logic [63:0] w;
        w = shr_arith(v + (64'd1 << (FRAC_GUARD - 1)), FRAC_GUARD);
        if (w + 64'h8000_0000 > LOW32) return w[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return w[31:0];
    endfunction

    // Fill the micro-rotation angles: atan(2^-i) / (2*pi) in 2^-48 turn
    task automatic build_rot_angles();
        logic [63:0] acc;
        logic [63:0] term;
        logic [63:0] d;
        int          n;
        for (int i = 0; i < STAGES; i++) begin
            if (i == 0) begin
                rot_angle[i] = 64'd1 << 45;
            end else begin
                acc = 64'd0;
                for (int k = 0; k < 64; k++) begin
                    d = 64'(2 * k + 1);
                    n = i * (2 * k + 1);
                    if (n <= 60) begin
                        term = (64'd1 << (60 - n)) / d;
                        acc  = (k % 2 == 1) ? acc - term : acc + term;
                    end
                end
                rot_angle[i] = (mul_upper(acc, TURN_RECIP) + 64'd2048) >> 12;
            end
        end
    endtask

    // Predict the result beat of one conversion
    function automatic t_result cordic_convert(input t_vec_req req);
        t_result     res;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] z;
        logic [63:0] dx;
        logic [63:0] dy;
        logic [63:0] t;
        res = '0;
        if (req.act == ACT_P2R) begin
            // Rotate (r, 0) by the angle; fold the left half plane first
            x = sign_ext32(req.rad) << FRAC_GUARD;
            y = 64'd0;
            z = {16'd0, req.ang, 16'd0};
            t = z >> 46;
            if (t == 64'd1 || t == 64'd2) begin
                x = 64'd0 - x;
                z = (z - HALF_REV) & LOW48;
            end
            for (int i = 0; i < STAGES; i++) begin
                dx = shr_arith(y, i);
                dy = shr_arith(x, i);
                if (z[47] == 1'b0) begin
                    x = x - dx;
                    y = y + dy;
                    z = (z - rot_angle[i]) & LOW48;
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = (z + rot_angle[i]) & LOW48;
                end
            end
            res.out_x = round_clip_s32(drop_gain(x));
            res.out_y = round_clip_s32(drop_gain(y));
            return res;
        end
        // Vector onto the positive x axis, accumulating the angle
        x = sign_ext32(req.cx) << FRAC_GUARD;
        y = sign_ext32(req.cy) << FRAC_GUARD;
        if (x == 64'd0 && y == 64'd0) return res;
        z = 64'd0;
        if (x[63]) begin
            x = 64'd0 - x;
            y = 64'd0 - y;
            z = HALF_REV;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = shr_arith(y, i);
            dy = shr_arith(x, i);
            if (y[63]) begin
                x = x - dx;
                y = y + dy;
                z = (z - rot_angle[i]) & LOW48;
            end else begin
                x = x + dx;
                y = y - dy;
                z = (z + rot_angle[i]) & LOW48;
            end
        end
        x = drop_gain(x);
        if (x[63]) begin
            res.out_radius = 32'd0;
        end else begin
            t = (x + (64'd1 << (FRAC_GUARD - 1))) >> FRAC_GUARD;
            res.out_radius = (t > LOW32) ? 32'hFFFF_FFFF : t[31:0];
        end
        t = ((z + (64'd1 << 15)) >> 16) & LOW32;
        res.out_angle = t[31:0];
        return res;
    endfunction

    // Idle length: mostly none, some short, a few long; none in a calm stretch
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Coordinate of random sign and magnitude, extremes now and then
    function automatic logic [31:0] rand_coord();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2, 3: v = $urandom();
            default: v = 32'($signed($urandom()) >>> $urandom_range(0, 31));
        endcase
        return v;
    endfunction

    task automatic add_vec(input logic act, input logic [31:0] cx, input logic [31:0] cy,
                           input logic [31:0] rad, input logic [31:0] ang);
        t_vec_req req;
        req.act = act;
        req.cx  = cx;
        req.cy  = cy;
        req.rad = rad;
        req.ang = ang;
        vectors_to_send.push_back(req);
    endtask

    // Driver: present queued vectors, predict each accepted beat
    int drv_gap;
    int drv_phase;
    bit drv_calm;

    always @(posedge i_clk) begin
        t_vec_req req;
        if (!i_rst_n) begin
            vec_in.valid     <= 1'b0;
            vec_in.action    <= ACT_P2R;
            vec_in.coord_x   <= '0;
            vec_in.coord_y   <= '0;
            vec_in.radius_in <= '0;
            vec_in.angle_in  <= '0;
            drv_gap   = 0;
            drv_phase = 200;
            drv_calm  = 1'b0;
        end else begin
            if (vec_in.valid && vec_in.ready) begin
                req.act = vec_in.action;
                req.cx  = vec_in.coord_x;
                req.cy  = vec_in.coord_y;
                req.rad = vec_in.radius_in;
                req.ang = vec_in.angle_in;
                results_due.push_back(cordic_convert(req));
                n_sent++;
            end
            if (drv_phase == 0) begin
                drv_calm  = ~drv_calm;
                drv_phase = $urandom_range(50, 300);
            end else begin
                drv_phase--;
            end
            if (!vec_in.valid || vec_in.ready) begin
                if (drv_gap > 0 || vectors_to_send.size() == 0) begin
                    if (drv_gap > 0) drv_gap--;
                    vec_in.valid <= 1'b0;
                end else begin
                    req = vectors_to_send.pop_front();
                    vec_in.valid     <= 1'b1;
                    vec_in.action    <= req.act;
                    vec_in.coord_x   <= req.cx;
                    vec_in.coord_y   <= req.cy;
                    vec_in.radius_in <= req.rad;
                    vec_in.angle_in  <= req.ang;
                    drv_gap = pick_gap(drv_calm);
                end
            end
        end
    end

    // Monitor: stall at random, check each result beat against the oldest due
    int mon_gap;
    int mon_phase;
    bit mon_calm;

    always @(posedge i_clk) begin
        t_result due;
        if (!i_rst_n) begin
            vec_out.ready <= 1'b0;
            mon_gap   = 0;
            mon_phase = 150;
            mon_calm  = 1'b0;
        end else begin
            if (vec_out.valid && vec_out.ready) begin
                if (results_due.size() == 0) begin
                    n_fail++;
                    if (n_reported < MAX_REPORTS) begin
                        n_reported++;
                        $display("unexpected result beat: x=%h y=%h r=%h a=%h",
                                 vec_out.out_x, vec_out.out_y, vec_out.out_radius,
                                 vec_out.out_angle);
                    end
                end else begin
                    due = results_due.pop_front();
                    if (vec_out.out_x !== due.out_x || vec_out.out_y !== due.out_y ||
                        vec_out.out_radius !== due.out_radius ||
                        vec_out.out_angle !== due.out_angle) begin
                        n_fail++;
                        if (n_reported < MAX_REPORTS) begin
                            n_reported++;
                            $display("mismatch: exp x=%h y=%h r=%h a=%h got x=%h y=%h r=%h a=%h",
                                     due.out_x, due.out_y, due.out_radius, due.out_angle,
                                     vec_out.out_x, vec_out.out_y, vec_out.out_radius,
                                     vec_out.out_angle);
                        end
                    end
                end
            end
            if (mon_phase == 0) begin
                mon_calm  = ~mon_calm;
                mon_phase = $urandom_range(50, 300);
            end else begin
                mon_phase--;
            end
            if (mon_gap > 0) begin
                mon_gap--;
                vec_out.ready <= 1'b0;
            end else begin
                vec_out.ready <= 1'b1;
                mon_gap = pick_gap(mon_calm);
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        logic        act;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] ang;
        i_rst_n = 1'b0;
        build_rot_angles();

        // Polar to rectangular: quadrant edges, extremes, saturation, negative radius
        add_vec(ACT_P2R, 32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF, 32'h0000_0000);
        add_vec(ACT_P2R, 32'h0, 32'h0, 32'h8000_0000, 32'h0000_0000);
        add_vec(ACT_P2R, 32'h0, 32'h0, 32'h0000_0000, 32'h4000_0000);
        add_vec(ACT_P2R, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000, 32'h4000_0000);
        add_vec(ACT_P2R, 32'h0, 32'h0, 32'h0001_0000, 32'h8000_0000);
        add_vec(ACT_P2R, 32'h0, 32'h0, 32'h0001_0000, 32'hC000_0000);
        add_vec(ACT_P2R, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_vec(ACT_P2R, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h2000_0000);
        add_vec(ACT_P2R, 32'h0, 32'h0, 32'h8000_0000, 32'hA000_0000);
        add_vec(ACT_P2R, 32'h0, 32'h0, 32'hFFFF_0000, 32'h4000_0000);
        add_vec(ACT_P2R, 32'h0, 32'h0, 32'h0000_0001, 32'h3FFF_FFFF);
        add_vec(ACT_P2R, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000);
        // Rectangular to polar: zero vector, axes, extremes, wrap near a full turn
        add_vec(ACT_R2P, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_vec(ACT_R2P, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0);
        add_vec(ACT_R2P, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
        add_vec(ACT_R2P, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
        add_vec(ACT_R2P, 32'h0, 32'h8000_0000, 32'h0, 32'h0);
        add_vec(ACT_R2P, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0);
        add_vec(ACT_R2P, 32'h0000_0001, 32'h0, 32'h0, 32'h0);
        add_vec(ACT_R2P, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
        add_vec(ACT_R2P, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
        add_vec(ACT_R2P, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0);
        add_vec(ACT_R2P, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        add_vec(ACT_R2P, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);

        // Random vectors; unused fields carry random data too
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            act = $urandom_range(0, 1) ? ACT_R2P : ACT_P2R;
            cx  = rand_coord();
            cy  = rand_coord();
            case ($urandom_range(0, 7))
                0: cx = $urandom_range(0, 1) ? 32'd0 : 32'($signed($urandom_range(0, 15)) - 8);
                1: cy = $urandom_range(0, 1) ? 32'd0 : 32'($signed($urandom_range(0, 15)) - 8);
                2: begin
                    cx = 32'd0;
                    cy = 32'd0;
                end
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0)
                ang = {2'($urandom_range(0, 3)), 30'd0} + 32'($signed($urandom_range(0, 15)) - 8);
            else
                ang = $urandom();
            add_vec(act, cx, cy, rand_coord(), ang);
        end
        n_items = vectors_to_send.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every beat sent, every result seen, then settle
        while (n_sent < n_items) @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (3 * LATENCY) @(posedge i_clk);

        if (n_fail == 0 && results_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/cpc_pkg.sv
src/cpc_if.sv
src/cpc_pre.sv
src/cpc_stage.sv
src/cpc_post.sv
src/cartesian_polar_converter.sv
dv/cartesian_polar_converter_test.sv
